/* sv/pobt_pkg.sv */
// Package for the periodic / one-shot timer bank.
// Shared widths, action codes and the divide-by-1000 reciprocal constants.
// No dependencies.
`default_nettype none

package pobt_pkg;

   localparam int unsigned WORD_W            = 32;
   localparam int unsigned SLOT_FIELD_W      = 4;
   localparam int unsigned ADDR_SLOTS        = 16;
   localparam int unsigned DEFAULT_NUM_SLOTS = 16;

   // floor(x / 1000) == (x * DIV_MS_MAGIC) >> DIV_MS_SHIFT for every 32-bit x
   localparam logic [WORD_W-1:0] DIV_MS_MAGIC = 32'd2199023256;
   localparam int unsigned       DIV_MS_SHIFT = 41;

   typedef enum logic [1:0] {
      ACT_SCHED  = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_RUN    = 2'd3
   } action_type;

endpackage

`default_nettype wire

/* sv/pobt_mul.sv */
// Shared 32x32 multiplier with a registered full-width product.
// Depends on pobt_pkg for the word width.
`default_nettype none

module pobt_mul
   import pobt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [WORD_W-1:0]     op_a,
   input  wire logic [WORD_W-1:0]     op_b,
   output logic      [2*WORD_W-1:0]   prod
);

   logic [2*WORD_W-1:0] prod_ff;
   logic [2*WORD_W-1:0] prod_in;

   assign prod_in = (2*WORD_W)'(op_a) * (2*WORD_W)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* sv/periodic_oneshot_timer_bank_unit.sv */
// Timer bank top level: sequencer, slot stores and output register.
// Depends on pobt_pkg and pobt_mul.
//
// Usage:
//   req_* carries one item (schedule, cancel, tick or run) with valid/ready.
//   rsp_* carries expiry results with valid/ready; csr_we/csr_wdata load clk_hz.
//   Cancel and tick complete in the idle state. Schedule passes ST_MUL_Q,
//   ST_MUL_IV and ST_WRITE: the shared multiplier first forms clk_hz/1000
//   by reciprocal multiply, then the duration in ms times that, then one
//   add forms the deadline. Run visits one slot per cycle, unless stalled,
//   through a single compare and add, then closes the run in ST_FINISH.
//   A fired slot is held back one step so its last flag is known; the scan
//   stalls on a second hit while the output register is still full, and the
//   closing step waits the same way. A run with nothing due returns one
//   marker item.
//   req_ready is high only while the sequencer is idle; a finished result may
//   still wait in the output register while the next item is taken.
//   Reset (synchronous) clears now, clk_hz and all armed bits; no clearing
//   pass is needed.
`default_nettype none

module periodic_oneshot_timer_bank_unit
   import pobt_pkg::*;
#(
   parameter int unsigned NUM_SLOTS = DEFAULT_NUM_SLOTS
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_action,
   input  wire logic [SLOT_FIELD_W-1:0]  req_timer_slot,
   input  wire logic [WORD_W-1:0]        req_duration_ms,
   input  wire logic                     req_periodic,
   input  wire logic [WORD_W-1:0]        req_delta_cycles,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [SLOT_FIELD_W-1:0]       rsp_expired_slot,
   output logic                          rsp_fired,
   output logic                          rsp_last,
   input  wire logic                     csr_we,
   input  wire logic [WORD_W-1:0]        csr_wdata
);

   localparam int unsigned SLOT_CNT = (NUM_SLOTS < ADDR_SLOTS) ? NUM_SLOTS : ADDR_SLOTS;
   localparam int unsigned IDX_W    = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_Q,
      ST_MUL_IV,
      ST_WRITE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [WORD_W-1:0]         clk_hz_ff, clk_hz_in;
   logic [WORD_W-1:0]         now_ff, now_in;
   logic [SLOT_CNT-1:0]       armed_ff, armed_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [IDX_W-1:0]          pend_ff, pend_in;
   logic                      pend_vld_ff, pend_vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SLOT_FIELD_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                      rsp_fired_ff, rsp_fired_in;
   logic                      rsp_last_ff, rsp_last_in;

   // latched schedule operands
   logic [SLOT_FIELD_W-1:0]   sch_slot_ff, sch_slot_in;
   logic [WORD_W-1:0]         sch_ms_ff, sch_ms_in;
   logic                      sch_per_ff, sch_per_in;

   logic [WORD_W-1:0]         interval_ff [SLOT_CNT];
   logic [WORD_W-1:0]         deadline_ff [SLOT_CNT];
   logic                      reload_ff   [SLOT_CNT];

   logic [WORD_W-1:0]         mul_a, mul_b;
   logic [2*WORD_W-1:0]       mul_p;
   logic [WORD_W-1:0]         add_b, add_sum;
   logic                      hit, can_push, scan_end;
   logic                      req_slot_ok, sch_slot_ok;
   logic                      sch_wr, dl_wr;
   action_type                act;

   pobt_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   assign act         = action_type'(req_action);
   assign req_slot_ok = WORD_W'(req_timer_slot) < WORD_W'(SLOT_CNT);
   assign sch_slot_ok = WORD_W'(sch_slot_ff) < WORD_W'(SLOT_CNT);

   // first pass: clk_hz * magic; second pass: duration in ms * (clk_hz / 1000)
   assign mul_a = (state_ff == ST_MUL_Q) ? clk_hz_ff : sch_ms_ff;
   assign mul_b = (state_ff == ST_MUL_Q) ? DIV_MS_MAGIC
                                         : WORD_W'(mul_p[2*WORD_W-1:DIV_MS_SHIFT]);

   // single adder on now: tick, schedule deadline, periodic reload
   always_comb begin
      unique case (state_ff)
         ST_SCAN:  add_b = interval_ff[idx_ff];
         ST_WRITE: add_b = mul_p[WORD_W-1:0];
         default:  add_b = req_delta_cycles;
      endcase
   end
   assign add_sum = now_ff + add_b;

   assign hit      = armed_ff[idx_ff] && (deadline_ff[idx_ff] <= now_ff);
   assign can_push = !rsp_valid_ff || rsp_ready;
   assign scan_end = idx_ff == IDX_W'(SLOT_CNT - 1);

   always_comb begin
      state_in     = state_ff;
      clk_hz_in    = csr_we ? csr_wdata : clk_hz_ff;
      now_in       = now_ff;
      armed_in     = armed_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_fired_in = rsp_fired_ff;
      rsp_last_in  = rsp_last_ff;
      sch_slot_in  = sch_slot_ff;
      sch_ms_in    = sch_ms_ff;
      sch_per_in   = sch_per_ff;
      sch_wr       = 1'b0;
      dl_wr        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (act)
                  ACT_SCHED: begin
                     sch_slot_in = req_timer_slot;
                     sch_ms_in   = req_duration_ms;
                     sch_per_in  = req_periodic;
                     state_in    = ST_MUL_Q;
                  end
                  ACT_CANCEL: begin
                     if (req_slot_ok) begin
                        armed_in[req_timer_slot[IDX_W-1:0]] = 1'b0;
                     end
                  end
                  ACT_TICK: begin
                     now_in = add_sum;
                  end
                  ACT_RUN: begin
                     idx_in      = '0;
                     pend_vld_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
               endcase
            end
         end
         ST_MUL_Q: begin
            state_in = ST_MUL_IV;
         end
         ST_MUL_IV: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (sch_slot_ok) begin
               armed_in[sch_slot_ff[IDX_W-1:0]] = 1'b1;
               sch_wr = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // a second hit needs the output register free for the held one
            if (!(hit && pend_vld_ff && !can_push)) begin
               if (hit) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_slot_in  = SLOT_FIELD_W'(pend_ff);
                     rsp_fired_in = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in     = idx_ff;
                  pend_vld_in = 1'b1;
                  if (reload_ff[idx_ff]) begin
                     dl_wr = 1'b1;
                  end else begin
                     armed_in[idx_ff] = 1'b0;
                  end
               end
               if (scan_end) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (can_push) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = pend_vld_ff ? SLOT_FIELD_W'(pend_ff) : '0;
               rsp_fired_in = pend_vld_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_hz_ff    <= '0;
         now_ff       <= '0;
         armed_ff     <= '0;
         idx_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_hz_ff    <= clk_hz_in;
         now_ff       <= now_in;
         armed_ff     <= armed_in;
         idx_ff       <= idx_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_last_ff  <= rsp_last_in;
      sch_slot_ff  <= sch_slot_in;
      sch_ms_ff    <= sch_ms_in;
      sch_per_ff   <= sch_per_in;
   end

   // slot stores: no reset, read only behind an armed bit
   always_ff @(posedge clock) begin
      if (sch_wr) begin
         interval_ff[sch_slot_ff[IDX_W-1:0]] <= mul_p[WORD_W-1:0];
         deadline_ff[sch_slot_ff[IDX_W-1:0]] <= add_sum;
         reload_ff[sch_slot_ff[IDX_W-1:0]]   <= sch_per_ff;
      end else if (dl_wr) begin
         deadline_ff[idx_ff] <= add_sum;
      end
   end

   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_slot = rsp_slot_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

/* verif/timer_expiry_checker.sv */
`timescale 1ns / 100ps
// Expiry checker for the timer bank: keeps its own copy of the slot state,
// predicts the expiry items of every accepted run and compares the rsp channel.
// Depends on pobt_pkg.

module timer_expiry_checker
   import pobt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [1:0]               req_action,
   input  wire logic [SLOT_FIELD_W-1:0]  req_timer_slot,
   input  wire logic [WORD_W-1:0]        req_duration_ms,
   input  wire logic                     req_periodic,
   input  wire logic [WORD_W-1:0]        req_delta_cycles,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic [SLOT_FIELD_W-1:0]  rsp_expired_slot,
   input  wire logic                     rsp_fired,
   input  wire logic                     rsp_last,
   input  wire logic                     csr_we,
   input  wire logic [WORD_W-1:0]        csr_wdata,
   output int                            mismatch_count,
   output int                            pending_count,
   output int                            checked_count
);

   localparam int unsigned       NUM_SLOTS  = DEFAULT_NUM_SLOTS;
   localparam logic [WORD_W-1:0] MS_PER_SEC = 32'd1000;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    fired;
      logic                    last;
   } expiry_type;

   expiry_type        due_expiries[$];
   logic [WORD_W-1:0] clk_hz_shadow;
   logic [WORD_W-1:0] now_cycles;
   logic              armed[NUM_SLOTS];
   logic              reload[NUM_SLOTS];
   logic [WORD_W-1:0] period_cycles[NUM_SLOTS];
   logic [WORD_W-1:0] deadline[NUM_SLOTS];
   int                errors;
   int                checked;

   task automatic advance_timer_bank(input action_type act,
                                     input logic [SLOT_FIELD_W-1:0] slot,
                                     input logic [WORD_W-1:0] ms,
                                     input logic per,
                                     input logic [WORD_W-1:0] delta);
      logic [WORD_W-1:0] iv;
      expiry_type        held;
      logic              have_held;
      have_held = 1'b0;
      held      = '0;
      unique case (act)
         ACT_SCHED: begin
            if (slot < NUM_SLOTS) begin
               iv                  = ms * (clk_hz_shadow / MS_PER_SEC);
               period_cycles[slot] = iv;
               reload[slot]        = per;
               deadline[slot]      = now_cycles + iv;
               armed[slot]         = 1'b1;
            end
         end
         ACT_CANCEL: begin
            if (slot < NUM_SLOTS)
               armed[slot] = 1'b0;
         end
         ACT_TICK: begin
            now_cycles = now_cycles + delta;
         end
         default: begin
            // a hit is held until the next one shows up, so last is known
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (armed[i] && deadline[i] <= now_cycles) begin
                  if (have_held)
                     due_expiries.push_back(held);
                  held.slot  = i[SLOT_FIELD_W-1:0];
                  held.fired = 1'b1;
                  held.last  = 1'b0;
                  have_held  = 1'b1;
                  if (reload[i])
                     deadline[i] = now_cycles + period_cycles[i];
                  else
                     armed[i] = 1'b0;
               end
            end
            if (!have_held) begin
               held.slot  = '0;
               held.fired = 1'b0;
            end
            held.last = 1'b1;
            due_expiries.push_back(held);
         end
      endcase
   endtask

   task automatic check_expiry_item();
      expiry_type want;
      if (due_expiries.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t unexpected expiry item: slot %0d fired %0b last %0b",
                     $realtime, rsp_expired_slot, rsp_fired, rsp_last);
      end else begin
         want = due_expiries.pop_front();
         checked++;
         if (want.slot !== rsp_expired_slot || want.fired !== rsp_fired ||
             want.last !== rsp_last) begin
            errors++;
            if (errors <= 10)
               $display("%0t mismatch: want slot %0d f %0b l %0b, got slot %0d f %0b l %0b",
                        $realtime, want.slot, want.fired, want.last,
                        rsp_expired_slot, rsp_fired, rsp_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clk_hz_shadow = '0;
         now_cycles    = '0;
         for (int i = 0; i < NUM_SLOTS; i++)
            armed[i] = 1'b0;
         due_expiries.delete();
         errors  = 0;
         checked = 0;
      end else begin
         if (csr_we)
            clk_hz_shadow = csr_wdata;
         // results out before the new item, so a result can never match its own run
         if (rsp_valid && rsp_ready)
            check_expiry_item();
         if (req_valid && req_ready)
            advance_timer_bank(action_type'(req_action), req_timer_slot, req_duration_ms,
                               req_periodic, req_delta_cycles);
      end
      mismatch_count <= errors;
      pending_count  <= due_expiries.size();
      checked_count  <= checked;
   end

endmodule

/* verif/tb_periodic_oneshot_timer_bank_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the timer bank: clock, reset, stimulus and verdict.
// Depends on pobt_pkg, periodic_oneshot_timer_bank_unit and timer_expiry_checker.

module tb_periodic_oneshot_timer_bank_unit
   import pobt_pkg::*;
();

   localparam logic [WORD_W-1:0] MS_PER_SEC = 32'd1000;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic [1:0]              req_action       = ACT_RUN;
   logic [SLOT_FIELD_W-1:0] req_timer_slot   = '0;
   logic [WORD_W-1:0]       req_duration_ms  = '0;
   logic                    req_periodic     = 1'b0;
   logic [WORD_W-1:0]       req_delta_cycles = '0;
   logic                    rsp_ready        = 1'b0;
   logic                    csr_we           = 1'b0;
   logic [WORD_W-1:0]       csr_wdata        = '0;
   logic                    req_ready;
   logic                    rsp_valid;
   logic [SLOT_FIELD_W-1:0] rsp_expired_slot;
   logic                    rsp_fired;
   logic                    rsp_last;

   logic                    steady        = 1'b0;
   logic [WORD_W-1:0]       cycles_per_ms = '0;
   int                      items_sent    = 0;
   int                      settings_used = 0;
   int                      mismatch_count;
   int                      pending_count;
   int                      checked_count;

   always #5 clock = ~clock;

   periodic_oneshot_timer_bank_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_timer_slot   (req_timer_slot),
      .req_duration_ms  (req_duration_ms),
      .req_periodic     (req_periodic),
      .req_delta_cycles (req_delta_cycles),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_expired_slot (rsp_expired_slot),
      .rsp_fired        (rsp_fired),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   timer_expiry_checker expiry_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_timer_slot   (req_timer_slot),
      .req_duration_ms  (req_duration_ms),
      .req_periodic     (req_periodic),
      .req_delta_cycles (req_delta_cycles),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_expired_slot (rsp_expired_slot),
      .rsp_fired        (rsp_fired),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(0, 99) >= 33);

   // valid stays up after an accept; it drops only for a gap, before a csr write or at the end
   task automatic send_item(input action_type act, input logic [SLOT_FIELD_W-1:0] slot,
                            input logic [WORD_W-1:0] ms, input logic per,
                            input logic [WORD_W-1:0] delta);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_timer_slot   <= slot;
      req_duration_ms  <= ms;
      req_periodic     <= per;
      req_delta_cycles <= delta;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_clk_hz(input logic [WORD_W-1:0] hz);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      // a schedule may still be in the multiplier
      repeat (30) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= hz;
      @(posedge clock);
      csr_we        <= 1'b0;
      cycles_per_ms  = hz / MS_PER_SEC;
      settings_used++;
   endtask

   function automatic logic [WORD_W-1:0] pick_ms();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(0, 12);
      return $urandom();
   endfunction

   function automatic logic [WORD_W-1:0] pick_delta();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(0, 6) * cycles_per_ms + $urandom_range(0, 3);
      return $urandom();
   endfunction

   // arm every slot close to now, then let them all come due in one run
   task automatic burst_fire();
      for (int s = 0; s < 16; s++)
         send_item(ACT_SCHED, s[SLOT_FIELD_W-1:0], $urandom_range(0, 2),
                   $urandom_range(0, 1) != 0, $urandom());
      send_item(ACT_TICK, 4'($urandom_range(0, 15)), $urandom(), 1'b0,
                3 * cycles_per_ms);
      send_item(ACT_RUN, 4'($urandom_range(0, 15)), $urandom(), 1'b1, $urandom());
   endtask

   task automatic random_phase(input int n_items);
      int stop_at;
      int roll;
      stop_at = items_sent + n_items;
      burst_fire();
      while (items_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 4)
            burst_fire();
         else if (roll < 36)
            send_item(ACT_SCHED, 4'($urandom_range(0, 15)), pick_ms(),
                      $urandom_range(0, 1) != 0, $urandom());
         else if (roll < 46)
            send_item(ACT_CANCEL, 4'($urandom_range(0, 15)), $urandom(),
                      $urandom_range(0, 1) != 0, $urandom());
         else if (roll < 70)
            send_item(ACT_TICK, 4'($urandom_range(0, 15)), $urandom(),
                      $urandom_range(0, 1) != 0, pick_delta());
         else
            send_item(ACT_RUN, 4'($urandom_range(0, 15)), $urandom(),
                      $urandom_range(0, 1) != 0, $urandom());
      end
   endtask

   task automatic directed_items();
      send_item(ACT_RUN,    4'd0,  32'd0,          1'b0, 32'd0);   // empty bank: marker
      send_item(ACT_SCHED,  4'd0,  32'd0,          1'b0, 32'd0);
      send_item(ACT_SCHED,  4'd15, 32'd0,          1'b1, 32'd0);
      send_item(ACT_RUN,    4'd0,  32'd0,          1'b0, 32'd0);
      send_item(ACT_RUN,    4'd0,  32'd0,          1'b0, 32'd0);   // zero-period slot again
      send_item(ACT_CANCEL, 4'd15, 32'd0,          1'b0, 32'd0);
      send_item(ACT_CANCEL, 4'd3,  32'd0,          1'b0, 32'd0);   // slot not armed
      send_item(ACT_RUN,    4'd0,  32'd0,          1'b0, 32'd0);
      send_item(ACT_SCHED,  4'd5,  32'hFFFF_FFFF,  1'b0, 32'd0);
      send_item(ACT_SCHED,  4'd6,  32'd10,         1'b1, 32'd0);
      send_item(ACT_SCHED,  4'd6,  32'd3,          1'b1, 32'd0);   // overwrite armed slot
      send_item(ACT_TICK,   4'd0,  32'd0,          1'b0, 32'd3);
      send_item(ACT_RUN,    4'd0,  32'd0,          1'b0, 32'd0);
      send_item(ACT_TICK,   4'd0,  32'd0,          1'b0, 32'hFFFF_FFFF);
      send_item(ACT_SCHED,  4'd9,  32'd5,          1'b1, 32'd0);
      send_item(ACT_TICK,   4'd0,  32'd0,          1'b0, 32'hFFFF_FFF0);
      send_item(ACT_RUN,    4'd0,  32'd0,          1'b0, 32'd0);
      // deadline wraps past zero, so it is due at once
      send_item(ACT_SCHED,  4'd12, 32'd20,         1'b0, 32'd0);
      send_item(ACT_RUN,    4'd0,  32'd0,          1'b0, 32'd0);
      send_item(ACT_TICK,   4'd0,  32'd0,          1'b0, 32'd13);
      send_item(ACT_RUN,    4'd15, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF);
      send_item(ACT_CANCEL, 4'd9,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF);
      send_item(ACT_RUN,    4'd0,  32'd0,          1'b0, 32'd0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_clk_hz(32'd1000);
      directed_items();
      write_clk_hz(32'd0);
      random_phase(65);
      write_clk_hz(32'd999);
      random_phase(65);
      write_clk_hz(32'hFFFF_FFFF);
      steady = 1'b1;
      random_phase(65);
      steady = 1'b0;
      write_clk_hz($urandom());
      random_phase(65);
      write_clk_hz(32'd1000 * $urandom_range(1, 400));
      random_phase(65);
      write_clk_hz(32'd1000);
      random_phase(65);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);
      $display("Sent %0d items across %0d clk_hz settings; %0d expiry items compared.",
               items_sent, settings_used, checked_count);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d items sent", items_sent);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
